/* rtl/core/packet_framer_xor_checksum_defines.svh */
// Assertion macros shared by the packet framer RTL.
// Depends on nothing; files that assert include it by name.
`ifndef PACKET_FRAMER_XOR_CHECKSUM_DEFINES_SVH
`define PACKET_FRAMER_XOR_CHECKSUM_DEFINES_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define PFX_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true at a clock edge outside reset.
`define PFX_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PFX_ASSERT(name, clk, rst_n, prop, msg)
`define PFX_ASSERT_NEVER(name, clk, rst_n, cond, msg)
`endif

`endif

/* rtl/core/pfx_pkg.sv */
// Types and constants shared by the packet framer modules.
// Depends on nothing; every other module uses it by scoped names.
`default_nettype none

package pfx_pkg;

  // Bytes in a complete frame with no payload.
  localparam int unsigned FrameLen = 5;
  localparam int unsigned CountW = 3;
  localparam int unsigned CfgIdxW = 2;

  // Default depth of the command queue between front and back.
  localparam int unsigned QueueDepthDefault = 4;

  // Configuration reset values.
  localparam logic [7:0] StartMarkerReset = 8'd170;
  localparam logic [7:0] StopMarkerReset = 8'd85;
  localparam logic [7:0] MaxPayloadReset = 8'd64;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStartMarker = 2'd0,
    CfgStopMarker  = 2'd1,
    CfgMaxPayload  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    KindHeader  = 1'b0,
    KindPayload = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    StOk           = 2'd0,
    StTooLarge     = 2'd1,
    StNotOpen      = 2'd2,
    StAlreadyOpen  = 2'd3
  } status_e;

  // One input item.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] type_byte;
    logic [7:0] size_byte;
    logic [7:0] data_byte;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last;
    status_e    status;
  } out_item_t;

  // Configuration register file as seen by the front.
  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] stop_marker;
    logic [7:0] max_payload;
  } cfg_t;

  // Classified command: the result bytes of one input item.
  typedef struct packed {
    logic [FrameLen-1:0][7:0] bytes;
    logic [CountW-1:0]        count;
    status_e                  status;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/core/pfx_front.sv */
// Front end of the packet framer: accepts input items, tracks the open
// message and turns each item into a command. Depends on pfx_pkg.
`default_nettype none

module pfx_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire pfx_pkg::cfg_t    cfg_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire pfx_pkg::in_item_t in_data_i,
  input  wire logic             q_full_i,
  output logic                  q_push_o,
  output pfx_pkg::cmd_t         q_cmd_o
);

  logic       open_q, open_d;
  logic [7:0] rem_q, rem_d;
  logic [7:0] xor_q, xor_d;
  logic       accept;
  logic [7:0] hdr_sum;
  logic [7:0] pay_sum;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept;
  assign hdr_sum    = in_data_i.size_byte ^ in_data_i.type_byte;
  assign pay_sum    = xor_q ^ in_data_i.data_byte;

  // Classify the item and build its command and the next message state.
  always_comb begin
    open_d         = open_q;
    rem_d          = rem_q;
    xor_d          = xor_q;
    q_cmd_o.bytes  = '0;
    q_cmd_o.count  = pfx_pkg::CountW'(1);
    q_cmd_o.status = pfx_pkg::StOk;
    if (in_data_i.kind == pfx_pkg::KindHeader) begin
      if (open_q) begin
        q_cmd_o.status = pfx_pkg::StAlreadyOpen;
      end else if (in_data_i.size_byte > cfg_i.max_payload) begin
        q_cmd_o.status = pfx_pkg::StTooLarge;
      end else begin
        q_cmd_o.bytes[0] = cfg_i.start_marker;
        q_cmd_o.bytes[1] = in_data_i.size_byte;
        q_cmd_o.bytes[2] = in_data_i.type_byte;
        q_cmd_o.bytes[3] = hdr_sum;
        q_cmd_o.bytes[4] = cfg_i.stop_marker;
        if (in_data_i.size_byte == 8'd0) begin
          q_cmd_o.count = pfx_pkg::CountW'(5);
        end else begin
          q_cmd_o.count = pfx_pkg::CountW'(3);
          open_d        = 1'b1;
          rem_d         = in_data_i.size_byte;
          xor_d         = hdr_sum;
        end
      end
    end else begin
      if (!open_q) begin
        q_cmd_o.status = pfx_pkg::StNotOpen;
      end else begin
        q_cmd_o.bytes[0] = in_data_i.data_byte;
        rem_d            = rem_q - 8'd1;
        xor_d            = pay_sum;
        if (rem_q == 8'd1) begin
          // Last payload byte closes the frame with checksum and stop.
          q_cmd_o.bytes[1] = pay_sum;
          q_cmd_o.bytes[2] = cfg_i.stop_marker;
          q_cmd_o.count    = pfx_pkg::CountW'(3);
          open_d           = 1'b0;
          xor_d            = 8'd0;
        end
      end
    end
  end

  // Message state advances on each accepted transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      rem_q  <= 8'd0;
      xor_q  <= 8'd0;
    end else if (accept) begin
      open_q <= open_d;
      rem_q  <= rem_d;
      xor_q  <= xor_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pfx_fifo.sv */
// Small command queue between the front and back of the packet framer.
// Depends on pfx_pkg and the assertion macro header.
`default_nettype none
`include "packet_framer_xor_checksum_defines.svh"

module pfx_fifo #(
  parameter int unsigned Depth = pfx_pkg::QueueDepthDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire pfx_pkg::cmd_t wdata_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output pfx_pkg::cmd_t      rdata_o,
  output logic               empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  pfx_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == DepthCnt);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  // Storage for queued commands.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  `PFX_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o, "push into full queue")
  `PFX_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && empty_o, "pop from empty queue")
  `PFX_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= DepthCnt, "queue count beyond depth")

endmodule

`default_nettype wire

/* rtl/core/pfx_back.sv */
// Packet framer back end: plays out queued commands, one byte per cycle
// unless stalled, to the output register; depends on pfx_pkg, macro header.
`default_nettype none
`include "packet_framer_xor_checksum_defines.svh"

module pfx_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire pfx_pkg::cmd_t  head_i,
  input  wire logic           empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output pfx_pkg::out_item_t  out_data_o
);

  logic [pfx_pkg::CountW-1:0] idx_q;
  logic                       out_valid_q;
  pfx_pkg::out_item_t         out_q;
  logic                       emit;
  logic                       is_last;

  assign emit    = !empty_i && (!out_valid_q || out_ready_i);
  assign is_last = (idx_q == head_i.count - pfx_pkg::CountW'(1));
  assign pop_o   = emit && is_last;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Byte index within the current command and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        idx_q <= is_last ? '0 : idx_q + pfx_pkg::CountW'(1);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.frame_byte <= head_i.bytes[idx_q];
      out_q.last       <= is_last;
      out_q.status     <= head_i.status;
    end
  end

  `PFX_ASSERT(a_idx_in_range, clk_i, rst_ni, !empty_i |-> idx_q < head_i.count,
              "byte index past command length")
  `PFX_ASSERT(a_err_single, clk_i, rst_ni,
              out_valid_q && out_q.status != pfx_pkg::StOk |-> out_q.last,
              "error result not marked last")
  `PFX_ASSERT(a_idx_restart, clk_i, rst_ni, pop_o |=> idx_q == '0,
              "byte index not cleared after command")

endmodule

`default_nettype wire

/* rtl/core/packet_framer_xor_checksum.sv */
// Packet framer with XOR-8 checksum: START, SIZE, TYPE, payload, CHECKSUM, STOP.
// The first result byte passes the command queue, then the output register.
// Throughput: one result byte per cycle unless stalled, set by the single output
// register; bytes per item: payload 1, header or closing 3, zero-size header 5.
// Reset: asynchronous active low; clears message state and queue and returns
// the marker and size registers to their reset values.
`default_nettype none

module packet_framer_xor_checksum #(
  parameter int unsigned QueueDepth = pfx_pkg::QueueDepthDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [pfx_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]                  cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire pfx_pkg::in_item_t           in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output pfx_pkg::out_item_t               out_data_o
);

  pfx_pkg::cfg_t cfg_q;
  pfx_pkg::cmd_t push_cmd, head_cmd;
  logic          q_push, q_pop, q_full, q_empty;

  assign cfg_ready_o = 1'b1;

  // Configuration register file; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker <= pfx_pkg::StartMarkerReset;
      cfg_q.stop_marker  <= pfx_pkg::StopMarkerReset;
      cfg_q.max_payload  <= pfx_pkg::MaxPayloadReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pfx_pkg::CfgStartMarker: cfg_q.start_marker <= cfg_data_i;
        pfx_pkg::CfgStopMarker:  cfg_q.stop_marker  <= cfg_data_i;
        pfx_pkg::CfgMaxPayload:  cfg_q.max_payload  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Classification of input transfers.
  pfx_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (push_cmd)
  );

  // Command queue.
  pfx_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (head_cmd),
    .empty_o (q_empty)
  );

  // Byte playout.
  pfx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* tb/packet_framer_xor_checksum_tb.sv */
// Self-checking testbench for the packet framer with XOR-8 checksum.
// Runs a directed table and then random messages against a built-in predictor.
// Depends on pfx_pkg and packet_framer_xor_checksum.
`timescale 1ns / 100ps

module packet_framer_xor_checksum_tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned HoldCycles = 120;
  // Register index with no register behind it; writes to it are dropped.
  localparam logic [pfx_pkg::CfgIdxW-1:0] CfgSpareIndex = 2'd3;

  // One row of the directed table: a register write or an input item.
  typedef struct {
    bit                          is_cfg;
    logic [pfx_pkg::CfgIdxW-1:0] idx;
    logic [7:0]                  val;
    pfx_pkg::in_item_t           item;
    bit                          pinned;
    pfx_pkg::status_e            pin_st;
  } step_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [pfx_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [7:0]                  cfg_data_i = '0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  pfx_pkg::in_item_t           in_data_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  pfx_pkg::out_item_t          out_data_o;

  // Predictor state and its copy of the registers.
  logic       open_msg = 1'b0;
  logic [7:0] left_bytes = '0;
  logic [7:0] xor_acc = '0;
  logic [7:0] start_byte = pfx_pkg::StartMarkerReset;
  logic [7:0] stop_byte = pfx_pkg::StopMarkerReset;
  logic [7:0] size_limit = pfx_pkg::MaxPayloadReset;

  pfx_pkg::out_item_t step_bytes[$];
  pfx_pkg::out_item_t frame_bytes_due[$];
  step_t              directed_steps[$];
  int unsigned        fail_count = 0;
  int unsigned        cycle_count = 0;

  // Flow control knobs shared by the sender and the receiver.
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  bit          rx_burst = 1'b0;
  bit          tx_burst = 1'b0;
  int unsigned burst_left = 0;

  packet_framer_xor_checksum dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout with %0d frame bytes outstanding", $time,
               frame_bytes_due.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic void emit_byte(input logic [7:0] b, input pfx_pkg::status_e s);
    step_bytes.push_back(pfx_pkg::out_item_t'{b, 1'b0, s});
  endfunction

  // Computes the frame bytes caused by one input transfer into step_bytes.
  function automatic void predict_frame_bytes(input pfx_pkg::in_item_t it);
    pfx_pkg::out_item_t tail;
    logic [7:0]         sum;
    step_bytes.delete();
    if (it.kind == pfx_pkg::KindHeader) begin
      if (open_msg) begin
        emit_byte(8'h00, pfx_pkg::StAlreadyOpen);
      end else if (it.size_byte > size_limit) begin
        emit_byte(8'h00, pfx_pkg::StTooLarge);
      end else begin
        sum = it.size_byte ^ it.type_byte;
        emit_byte(start_byte, pfx_pkg::StOk);
        emit_byte(it.size_byte, pfx_pkg::StOk);
        emit_byte(it.type_byte, pfx_pkg::StOk);
        if (it.size_byte == 8'd0) begin
          emit_byte(sum, pfx_pkg::StOk);
          emit_byte(stop_byte, pfx_pkg::StOk);
        end else begin
          open_msg = 1'b1;
          left_bytes = it.size_byte;
          xor_acc = sum;
        end
      end
    end else begin
      if (!open_msg) begin
        emit_byte(8'h00, pfx_pkg::StNotOpen);
      end else begin
        xor_acc = xor_acc ^ it.data_byte;
        emit_byte(it.data_byte, pfx_pkg::StOk);
        left_bytes = left_bytes - 8'd1;
        if (left_bytes == 8'd0) begin
          emit_byte(xor_acc, pfx_pkg::StOk);
          emit_byte(stop_byte, pfx_pkg::StOk);
          open_msg = 1'b0;
          xor_acc = 8'h00;
        end
      end
    end
    tail = step_bytes.pop_back();
    tail.last = 1'b1;
    step_bytes.push_back(tail);
  endfunction

  // Next random item: mostly well-formed messages, some protocol noise.
  function automatic pfx_pkg::in_item_t next_frame_item();
    pfx_pkg::in_item_t it;
    int unsigned       r;
    int unsigned       lim;
    it.kind = pfx_pkg::KindHeader;
    it.type_byte = 8'($urandom);
    it.size_byte = 8'($urandom);
    it.data_byte = 8'($urandom);
    r = $urandom_range(99);
    if (open_msg) begin
      if (r >= 6) it.kind = pfx_pkg::KindPayload;
    end else if (r < 8) begin
      it.kind = pfx_pkg::KindPayload;
    end else if (r < 16 && size_limit != 8'hFF) begin
      it.size_byte = 8'($urandom_range(255, size_limit + 1));
    end else begin
      lim = ($urandom_range(9) == 0) ? 40 : 10;
      if (lim > size_limit) lim = size_limit;
      it.size_byte = (r < 28) ? 8'd0 : 8'($urandom_range(lim, 0));
    end
    return it;
  endfunction

  function automatic step_t row_item(input pfx_pkg::kind_e k, input logic [7:0] ty,
                                     input logic [7:0] sz, input logic [7:0] db);
    step_t s;
    s.is_cfg = 1'b0;
    s.idx = '0;
    s.val = '0;
    s.item = pfx_pkg::in_item_t'{k, ty, sz, db};
    s.pinned = 1'b0;
    s.pin_st = pfx_pkg::StOk;
    return s;
  endfunction

  // Row whose single error result is typed in directly.
  function automatic step_t row_pin(input pfx_pkg::kind_e k, input logic [7:0] ty,
                                    input logic [7:0] sz, input logic [7:0] db,
                                    input pfx_pkg::status_e st);
    step_t s;
    s = row_item(k, ty, sz, db);
    s.pinned = 1'b1;
    s.pin_st = st;
    return s;
  endfunction

  function automatic step_t row_cfg(input logic [pfx_pkg::CfgIdxW-1:0] idx,
                                    input logic [7:0] val);
    step_t s;
    s = row_item(pfx_pkg::KindHeader, 8'h00, 8'h00, 8'h00);
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.val = val;
    return s;
  endfunction

  // Offers one item, holds it until the transfer, then records its frame bytes.
  task automatic send_item(input pfx_pkg::in_item_t it, input bit pinned,
                           input pfx_pkg::status_e pin_st);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predict_frame_bytes(it);
    if (pinned) begin
      step_bytes.delete();
      step_bytes.push_back(pfx_pkg::out_item_t'{8'h00, 1'b1, pin_st});
    end
    foreach (step_bytes[i]) frame_bytes_due.push_back(step_bytes[i]);
  endtask

  // Idle time on the input side after a transfer.
  task automatic idle_gap();
    int unsigned g;
    if (burst_left != 0) begin
      burst_left--;
      g = 0;
    end else if (tx_burst) begin
      g = 0;
    end else begin
      g = pick_gap();
    end
    if ($urandom_range(15) == 0) tx_burst = !tx_burst;
    if (g != 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (g - 1) @(negedge clk_i);
    end
  endtask

  // Stops offering input until every predicted frame byte has been seen.
  task automatic wait_frames_drained();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk_i);
  endtask

  // Register write, only issued with the block idle.
  task automatic cfg_write(input logic [pfx_pkg::CfgIdxW-1:0] idx, input logic [7:0] val);
    wait_frames_drained();
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      pfx_pkg::CfgStartMarker: start_byte = val;
      pfx_pkg::CfgStopMarker:  stop_byte = val;
      pfx_pkg::CfgMaxPayload:  size_limit = val;
      default: ;
    endcase
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  // Output back-pressure, including one long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (rx_burst || $urandom_range(99) < 70) begin
      out_ready_i <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_ready_i <= (stall_left == 0);
    end
    if ($urandom_range(63) == 0) rx_burst = !rx_burst;
  end

  // Compares every output transfer with the oldest predicted frame byte.
  always @(posedge clk_i) begin
    pfx_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (frame_bytes_due.size() == 0) begin
        $display("%0t: unexpected output transfer byte=%h last=%b status=%0d", $time,
                 out_data_o.frame_byte, out_data_o.last, out_data_o.status);
        fail_count++;
      end else begin
        want = frame_bytes_due.pop_front();
        if (out_data_o.frame_byte !== want.frame_byte) begin
          $display("%0t: frame_byte expected %h actual %h", $time,
                   want.frame_byte, out_data_o.frame_byte);
          fail_count++;
        end
        if (out_data_o.last !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, out_data_o.last);
          fail_count++;
        end
        if (out_data_o.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, out_data_o.status);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [7:0]  st;
    logic [7:0]  sp;
    logic [7:0]  mx;
    int unsigned cnt;

    // Directed table: reset values, extremes, every error and mid-message writes.
    directed_steps.push_back(row_pin(pfx_pkg::KindPayload, 8'hFF, 8'hFF, 8'hFF,
                                     pfx_pkg::StNotOpen));
    directed_steps.push_back(row_pin(pfx_pkg::KindHeader, 8'h00, 8'd65, 8'h00,
                                     pfx_pkg::StTooLarge));
    directed_steps.push_back(row_pin(pfx_pkg::KindHeader, 8'hFF, 8'hFF, 8'hFF,
                                     pfx_pkg::StTooLarge));
    directed_steps.push_back(row_item(pfx_pkg::KindHeader, 8'h00, 8'h00, 8'h00));
    directed_steps.push_back(row_item(pfx_pkg::KindHeader, 8'hFF, 8'd1, 8'h00));
    directed_steps.push_back(row_pin(pfx_pkg::KindHeader, 8'h12, 8'h00, 8'h00,
                                     pfx_pkg::StAlreadyOpen));
    directed_steps.push_back(row_item(pfx_pkg::KindPayload, 8'h00, 8'h00, 8'hFF));
    directed_steps.push_back(row_cfg(pfx_pkg::CfgStopMarker, 8'h00));
    directed_steps.push_back(row_cfg(pfx_pkg::CfgStartMarker, 8'hFF));
    directed_steps.push_back(row_cfg(CfgSpareIndex, 8'h7E));
    directed_steps.push_back(row_item(pfx_pkg::KindHeader, 8'h80, 8'd3, 8'h00));
    directed_steps.push_back(row_item(pfx_pkg::KindPayload, 8'hFF, 8'hFF, 8'h00));
    directed_steps.push_back(row_cfg(pfx_pkg::CfgStopMarker, 8'hFF));
    directed_steps.push_back(row_cfg(pfx_pkg::CfgMaxPayload, 8'h00));
    directed_steps.push_back(row_pin(pfx_pkg::KindHeader, 8'h01, 8'd200, 8'h00,
                                     pfx_pkg::StAlreadyOpen));
    directed_steps.push_back(row_item(pfx_pkg::KindPayload, 8'h00, 8'h00, 8'h01));
    directed_steps.push_back(row_item(pfx_pkg::KindPayload, 8'h00, 8'h00, 8'h7F));
    directed_steps.push_back(row_pin(pfx_pkg::KindHeader, 8'h00, 8'd1, 8'h00,
                                     pfx_pkg::StTooLarge));
    directed_steps.push_back(row_item(pfx_pkg::KindHeader, 8'hAA, 8'h00, 8'h00));
    directed_steps.push_back(row_cfg(pfx_pkg::CfgMaxPayload, 8'hFF));
    directed_steps.push_back(row_cfg(pfx_pkg::CfgStartMarker, 8'h00));
    directed_steps.push_back(row_item(pfx_pkg::KindHeader, 8'h3C, 8'd2, 8'h00));
    directed_steps.push_back(row_pin(pfx_pkg::KindHeader, 8'h00, 8'hFF, 8'h00,
                                     pfx_pkg::StAlreadyOpen));
    directed_steps.push_back(row_item(pfx_pkg::KindPayload, 8'h00, 8'h00, 8'h55));
    directed_steps.push_back(row_item(pfx_pkg::KindPayload, 8'h00, 8'h00, 8'hAA));
    directed_steps.push_back(row_pin(pfx_pkg::KindPayload, 8'h00, 8'h00, 8'h00,
                                     pfx_pkg::StNotOpen));

    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    foreach (directed_steps[k]) begin
      if (directed_steps[k].is_cfg) begin
        cfg_write(directed_steps[k].idx, directed_steps[k].val);
      end else begin
        send_item(directed_steps[k].item, directed_steps[k].pinned, directed_steps[k].pin_st);
        idle_gap();
      end
    end

    // Random phases, each under its own register setting.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin st = 8'h00; sp = 8'hFF; mx = 8'd8; cnt = 25; end
        1: begin st = 8'hFF; sp = 8'h00; mx = 8'd0; cnt = 15; end
        2: begin st = 8'($urandom); sp = 8'($urandom); mx = 8'hFF; cnt = 40; end
        default: begin
          st = 8'($urandom); sp = 8'($urandom); mx = 8'($urandom_range(20, 1)); cnt = 31;
        end
      endcase
      cfg_write(pfx_pkg::CfgStartMarker, st);
      cfg_write(pfx_pkg::CfgStopMarker, sp);
      cfg_write(pfx_pkg::CfgMaxPayload, mx);
      if (p == 2) cfg_write(CfgSpareIndex, 8'($urandom));
      for (int i = 0; i < cnt; i++) begin
        // Long output hold-off while the input keeps streaming.
        if (p == 2 && i == 5) begin
          hold_req = 1'b1;
          burst_left = 24;
        end
        // Input pause until everything outstanding has come out.
        if (p == 3 && i == 17) wait_frames_drained();
        send_item(next_frame_item(), 1'b0, pfx_pkg::StOk);
        idle_gap();
      end
    end

    wait_frames_drained();
    repeat (SettleCycles * 4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
